>>> hw/rtl/ipv4_blocklist_packet_filter_top_macros.svh
// ============================================================================
// IPv4 blocklist packet filter: assertion macros
// Shared property macros for the port-level checker. The including module
// must have i_clk and i_rst_n in scope.
// ============================================================================
`ifndef IPV4_BLOCKLIST_PACKET_FILTER_TOP_MACROS_SVH
`define IPV4_BLOCKLIST_PACKET_FILTER_TOP_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define IBPF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define IBPF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/ibpf_pkg.sv
// ============================================================================
// IPv4 blocklist packet filter: package
// Word types, operation and status codes, table geometry and the bucket hash.
// ============================================================================
package ibpf_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int BUCKET_WAYS   = 4;
    localparam int NBUCKETS      = TABLE_ENTRIES / BUCKET_WAYS;
    localparam int BKT_W         = $clog2(NBUCKETS);

    localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

    localparam logic [5:0] HDR_BYTES    = 6'd34;
    localparam logic [5:0] POS_ETH_HI   = 6'd12;
    localparam logic [5:0] POS_ETH_LO   = 6'd13;
    localparam logic [5:0] POS_PROTO    = 6'd23;
    localparam logic [5:0] POS_SRC_LO   = 6'd26;
    localparam logic [5:0] POS_SRC_HI   = 6'd29;
    localparam logic [5:0] POS_DST_LO   = 6'd30;
    localparam logic [5:0] POS_DST_HI   = 6'd33;

    localparam logic [7:0] ETH_IPV4_HI  = 8'h08;
    localparam logic [7:0] ETH_IPV4_LO  = 8'h00;
    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [7:0] PROTO_UDP    = 8'd17;

    localparam logic [1:0] ETH_NONE     = 2'd0;
    localparam logic [1:0] ETH_HALF     = 2'd1;
    localparam logic [1:0] ETH_FULL     = 2'd2;

    localparam logic [2:0] F_FRAME      = 3'd0;
    localparam logic [2:0] F_ADD        = 3'd1;
    localparam logic [2:0] F_REMOVE     = 3'd2;
    localparam logic [2:0] F_HEARTBEAT  = 3'd3;
    localparam logic [2:0] F_TICK       = 3'd4;

    localparam logic [1:0] K_FRAME      = 2'd0;
    localparam logic [1:0] K_ADD        = 2'd1;
    localparam logic [1:0] K_REMOVE     = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [31:0] address;
    } t_in_word;

    typedef struct packed {
        logic [1:0] result_kind;
        logic       drop;
        logic [1:0] status;
    } t_out_word;

    typedef struct packed {
        logic        vld;
        logic [31:0] addr;
    } t_way;

    typedef t_way [BUCKET_WAYS-1:0] t_row;

    function automatic logic [BKT_W-1:0] bucket_of(input logic [31:0] m);
        logic [31:0] f;
        f = m ^ (m >> 16);
        return f[BKT_W-1:0];
    endfunction

endpackage

>>> hw/rtl/ipv4_blocklist_packet_filter_top.sv
// ============================================================================
// IPv4 blocklist packet filter: top level
// Frame header parser, bucketed blocked-address table and result pipeline.
// ============================================================================
// The block takes one word per cycle with no gaps while o_stall is low; a
// verdict or table status passes the multiply, bucket read and resolve stages
// and leaves through an output register that keeps the input side open while
// a result waits. The rate is set by the table memory, which has two read
// ports and one write port; the one writing stage forwards its row to a
// following read of the same bucket. After reset the table is cleared one
// bucket per cycle, which holds o_stall high; the timeout register can be written during that time.
module ipv4_blocklist_packet_filter_top
    import ibpf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in_word    i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_word   o_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    logic [31:0] r_timeout;
    logic [5:0]  r_pos, n_pos;
    logic [1:0]  r_eth, n_eth;
    logic        r_prot, n_prot;
    logic [31:0] r_src, n_src;
    logic [31:0] r_dst, n_dst;
    logic [31:0] r_now, n_now;
    logic [31:0] r_hb, n_hb;

    logic            r_clr_busy;
    logic [BKT_W-1:0] r_clr_idx;

    logic        r_s1_vld;
    logic [1:0]  r_s1_kind;
    logic        r_s1_elig;
    logic [31:0] r_s1_addr_a;
    logic [31:0] r_s1_addr_b;

    logic        r_s2_vld;
    logic [1:0]  r_s2_kind;
    logic        r_s2_elig;
    logic [31:0] r_s2_addr_a;
    logic [31:0] r_s2_addr_b;
    logic [31:0] r_s2_m_a;
    logic [31:0] r_s2_m_b;

    logic             r_s3_vld;
    logic [1:0]       r_s3_kind;
    logic             r_s3_elig;
    logic [31:0]      r_s3_addr_a;
    logic [31:0]      r_s3_addr_b;
    logic [BKT_W-1:0] r_s3_bkt_a;
    logic             r_fwd_a;
    logic             r_fwd_b;
    t_row             r_fwd_row;
    t_row             r_rd_a;
    t_row             r_rd_b;

    logic      r_out_vld;
    t_out_word r_out_word;

    t_row mem [NBUCKETS];

    logic             in_acc;
    logic             load_s1;
    logic [1:0]       load_kind;
    logic             load_elig;
    logic [31:0]      load_addr_a;
    logic [31:0]      load_addr_b;
    logic             auto_pass;
    logic [5:0]       pos_upd;
    logic [1:0]       eth_upd;
    logic             prot_upd;

    logic             out_free, s3_fire, s3_free, s2_adv, s2_free, s1_adv, s1_free;
    logic [BKT_W-1:0] bkt_a, bkt_b;
    t_row             row_a, row_b, s3_wrow;
    logic             hit_a, hit_b, any_free, found, s3_wr;
    logic [BUCKET_WAYS-1:0] match_a, free_sel;
    t_out_word        s3_word;
    logic             mem_we;
    logic [BKT_W-1:0] mem_waddr;
    t_row             mem_wdata;

    // Handshake and pipeline advance.
    assign out_free = !r_out_vld || !i_stall;
    assign s3_fire  = r_s3_vld && out_free;
    assign s3_free  = !r_s3_vld || out_free;
    assign s2_adv   = r_s2_vld && s3_free;
    assign s2_free  = !r_s2_vld || s3_free;
    assign s1_adv   = r_s1_vld && s2_free;
    assign s1_free  = !r_s1_vld || s2_free;
    assign o_stall  = r_clr_busy || !s1_free;
    assign in_acc   = i_valid && !o_stall;

    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_vld;
    assign o_data      = r_out_word;

    assign auto_pass = (r_timeout != 32'd0) &&
                       ({1'b0, r_now} > ({1'b0, r_hb} + {1'b0, r_timeout}));

    always_comb begin
        n_pos       = r_pos;
        n_eth       = r_eth;
        n_prot      = r_prot;
        n_src       = r_src;
        n_dst       = r_dst;
        n_now       = r_now;
        n_hb        = r_hb;
        pos_upd     = r_pos;
        eth_upd     = r_eth;
        prot_upd    = r_prot;
        load_s1     = 1'b0;
        load_kind   = K_FRAME;
        load_elig   = 1'b0;
        load_addr_a = i_data.address;
        load_addr_b = i_data.address;
        if (in_acc) begin
            case (i_data.func)
                F_FRAME: begin
                    if (r_pos == POS_ETH_HI) begin
                        eth_upd = (i_data.data_byte == ETH_IPV4_HI) ? ETH_HALF : ETH_NONE;
                    end else if (r_pos == POS_ETH_LO) begin
                        eth_upd = (r_eth == ETH_HALF && i_data.data_byte == ETH_IPV4_LO) ?
                                  ETH_FULL : ETH_NONE;
                    end else if (r_pos == POS_PROTO) begin
                        prot_upd = (i_data.data_byte == PROTO_TCP) ||
                                   (i_data.data_byte == PROTO_UDP);
                    end else if (r_pos >= POS_SRC_LO && r_pos <= POS_SRC_HI) begin
                        n_src = {r_src[23:0], i_data.data_byte};
                    end else if (r_pos >= POS_DST_LO && r_pos <= POS_DST_HI) begin
                        n_dst = {r_dst[23:0], i_data.data_byte};
                    end
                    if (r_pos < HDR_BYTES) begin
                        pos_upd = r_pos + 6'd1;
                    end
                    n_pos  = pos_upd;
                    n_eth  = eth_upd;
                    n_prot = prot_upd;
                    if (i_data.last_byte) begin
                        load_s1     = 1'b1;
                        load_kind   = K_FRAME;
                        load_elig   = (pos_upd >= HDR_BYTES) && (eth_upd == ETH_FULL) &&
                                      prot_upd && !auto_pass;
                        load_addr_a = n_dst;
                        load_addr_b = n_src;
                        n_pos       = 6'd0;
                        n_eth       = ETH_NONE;
                        n_prot      = 1'b0;
                    end
                end
                F_ADD: begin
                    load_s1   = 1'b1;
                    load_kind = K_ADD;
                end
                F_REMOVE: begin
                    load_s1   = 1'b1;
                    load_kind = K_REMOVE;
                end
                F_HEARTBEAT: begin
                    n_hb = r_now;
                end
                F_TICK: begin
                    n_now = r_now + 32'd1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= '0;
            r_pos     <= '0;
            r_eth     <= ETH_NONE;
            r_prot    <= 1'b0;
            r_src     <= '0;
            r_dst     <= '0;
            r_now     <= '0;
            r_hb      <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_timeout <= i_cfg_data;
            end
            r_pos  <= n_pos;
            r_eth  <= n_eth;
            r_prot <= n_prot;
            r_src  <= n_src;
            r_dst  <= n_dst;
            r_now  <= n_now;
            r_hb   <= n_hb;
        end
    end

    // Stage 1 multiplies, stage 2 reads the buckets, stage 3 resolves them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (load_s1) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_s2_vld <= 1'b1;
            end else if (s2_adv) begin
                r_s2_vld <= 1'b0;
            end
            if (s2_adv) begin
                r_s3_vld <= 1'b1;
            end else if (s3_fire) begin
                r_s3_vld <= 1'b0;
            end
            if (s3_fire) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign bkt_a = bucket_of(r_s2_m_a);
    assign bkt_b = bucket_of(r_s2_m_b);

    always_ff @(posedge i_clk) begin
        if (load_s1) begin
            r_s1_kind   <= load_kind;
            r_s1_elig   <= load_elig;
            r_s1_addr_a <= load_addr_a;
            r_s1_addr_b <= load_addr_b;
        end
        if (s1_adv) begin
            r_s2_kind   <= r_s1_kind;
            r_s2_elig   <= r_s1_elig;
            r_s2_addr_a <= r_s1_addr_a;
            r_s2_addr_b <= r_s1_addr_b;
            r_s2_m_a    <= r_s1_addr_a * HASH_MULT;
            r_s2_m_b    <= r_s1_addr_b * HASH_MULT;
        end
        if (s2_adv) begin
            r_s3_kind   <= r_s2_kind;
            r_s3_elig   <= r_s2_elig;
            r_s3_addr_a <= r_s2_addr_a;
            r_s3_addr_b <= r_s2_addr_b;
            r_s3_bkt_a  <= bkt_a;
            r_fwd_a     <= s3_fire && s3_wr && (r_s3_bkt_a == bkt_a);
            r_fwd_b     <= s3_fire && s3_wr && (r_s3_bkt_a == bkt_b);
            r_fwd_row   <= s3_wrow;
        end
        if (s3_fire) begin
            r_out_word <= s3_word;
        end
    end

    // Table memory: one write port, two read ports with registered data.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (s2_adv) begin
            r_rd_a <= mem[bkt_a];
            r_rd_b <= mem[bkt_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == BKT_W'(NBUCKETS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    assign mem_we    = r_clr_busy || (s3_fire && s3_wr);
    assign mem_waddr = r_clr_busy ? r_clr_idx : r_s3_bkt_a;
    assign mem_wdata = r_clr_busy ? t_row'('0) : s3_wrow;

    assign row_a = r_fwd_a ? r_fwd_row : r_rd_a;
    assign row_b = r_fwd_b ? r_fwd_row : r_rd_b;

    always_comb begin
        hit_b    = 1'b0;
        found    = 1'b0;
        match_a  = '0;
        free_sel = '0;
        s3_wrow  = row_a;
        for (int w = 0; w < BUCKET_WAYS; w++) begin
            match_a[w]  = row_a[w].vld && (row_a[w].addr == r_s3_addr_a);
            hit_b       = hit_b || (row_b[w].vld && (row_b[w].addr == r_s3_addr_b));
            free_sel[w] = !row_a[w].vld && !found;
            found       = found || !row_a[w].vld;
        end
        hit_a    = |match_a;
        any_free = found;
        for (int w = 0; w < BUCKET_WAYS; w++) begin
            if (r_s3_kind == K_ADD && !hit_a && free_sel[w]) begin
                s3_wrow[w].vld  = 1'b1;
                s3_wrow[w].addr = r_s3_addr_a;
            end else if (r_s3_kind == K_REMOVE && match_a[w]) begin
                s3_wrow[w] = '0;
            end
        end
        s3_wr = ((r_s3_kind == K_ADD) && !hit_a && any_free) ||
                ((r_s3_kind == K_REMOVE) && hit_a);
        s3_word.result_kind = r_s3_kind;
        s3_word.drop        = 1'b0;
        s3_word.status      = ST_OK;
        case (r_s3_kind)
            K_FRAME: begin
                s3_word.drop = r_s3_elig && (hit_a || hit_b);
            end
            K_ADD: begin
                s3_word.status = (!hit_a && !any_free) ? ST_FULL : ST_OK;
            end
            K_REMOVE: begin
                s3_word.status = hit_a ? ST_OK : ST_NOT_FOUND;
            end
            default: begin
            end
        endcase
    end

endmodule

>>> hw/rtl/ibpf_checker.sv
// ============================================================================
// IPv4 blocklist packet filter: port checker
// Checks result words and the output handshake as seen on the top level ports.
// ============================================================================
`include "ipv4_blocklist_packet_filter_top_macros.svh"

module ibpf_checker
    import ibpf_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input t_out_word   o_data
);

    `IBPF_ASSERT_SAME(a_kind_known, o_valid, o_data.result_kind <= K_REMOVE,
                      "unknown result kind")
    `IBPF_ASSERT_SAME(a_table_no_drop, o_valid && o_data.result_kind != K_FRAME,
                      !o_data.drop, "drop set on a table result")
    `IBPF_ASSERT_SAME(a_frame_no_status, o_valid && o_data.result_kind == K_FRAME,
                      o_data.status == ST_OK, "status set on a frame verdict")
    `IBPF_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_data),
                      "stalled result word changed")

endmodule

bind ipv4_blocklist_packet_filter_top ibpf_checker u_ibpf_checker (.*);
